/* hw/rtl/tdet_pkg.sv */
// ----------------------------------------------------------------------------
// tdet_pkg
// Shared types and constants of the timed event dedup table.
// ----------------------------------------------------------------------------
`default_nettype none
package tdet_pkg;
  localparam int unsigned Slots = 16;
  localparam int unsigned SlotW = $clog2(Slots);
  localparam int unsigned CntW = $clog2(Slots + 1);
  localparam logic [14:0] TtlMax = 15'd30000;

  localparam logic [1:0] OpSubmit = 2'd0;
  localparam logic [1:0] OpExpire = 2'd1;
  localparam logic [1:0] OpQuery = 2'd2;

  localparam logic [3:0] StAccepted = 4'd0;
  localparam logic [3:0] StDuplicate = 4'd1;
  localparam logic [3:0] StSchema = 4'd2;
  localparam logic [3:0] StDevice = 4'd3;
  localparam logic [3:0] StBoot = 4'd4;
  localparam logic [3:0] StTtl = 4'd5;
  localparam logic [3:0] StConflict = 4'd6;
  localparam logic [3:0] StExpired = 4'd7;
  localparam logic [3:0] StCapacity = 4'd8;

  localparam logic [0:0] CfgDevice = 1'b0;
  localparam logic [0:0] CfgBoot = 1'b1;

  // one slot record as read from the table
  typedef struct packed {
    logic [63:0] key;
    logic [63:0] print;
    logic [63:0] deadline;
    logic [14:0] first_ttl;
    logic [1:0]  severity;
  } rec_t;

  typedef struct packed {
    logic [3:0]  status;
    logic        accepted;
    logic        found;
    logic [1:0]  severity;
    logic [63:0] key;
    logic [14:0] remaining;
  } res_t;
endpackage
`default_nettype wire

/* hw/rtl/tdet_store.sv */
// ----------------------------------------------------------------------------
// tdet_store
// Slot record memory plus used and emitted flags.
// ----------------------------------------------------------------------------
`default_nettype none
module tdet_store (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic [tdet_pkg::SlotW-1:0] rd_idx_i,
  output tdet_pkg::rec_t                 rd_rec_o,
  output logic [tdet_pkg::Slots-1:0]     used_o,
  output logic [tdet_pkg::Slots-1:0]     emitted_o,
  input  wire logic                      wr_i,
  input  wire logic [tdet_pkg::SlotW-1:0] wr_idx_i,
  input  tdet_pkg::rec_t                 wr_rec_i,
  input  wire logic                      emit_i,
  input  wire logic [tdet_pkg::SlotW-1:0] emit_idx_i
);
  import tdet_pkg::*;

  rec_t mem_q [Slots];
  logic [Slots-1:0] used_q, emitted_q;

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wr_idx_i] <= wr_rec_i;
    end
    rd_rec_o <= mem_q[rd_idx_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
      emitted_q <= '0;
    end else begin
      if (wr_i) begin
        used_q[wr_idx_i] <= 1'b1;
        emitted_q[wr_idx_i] <= 1'b0;
      end
      if (emit_i) begin
        emitted_q[emit_idx_i] <= 1'b1;
      end
    end
  end

  assign used_o = used_q;
  assign emitted_o = emitted_q;
endmodule
`default_nettype wire

/* hw/rtl/ttl_dedup_event_table.sv */
// ----------------------------------------------------------------------------
// ttl_dedup_event_table
// Table of sixteen timed event records with submit, expire-next and query.
// ----------------------------------------------------------------------------
// An operation is taken when start_i is high and busy_o is low. Each one
// that passes the pre-sweep checks sweeps the sixteen slots through a single
// memory read port, one slot a cycle, then finishes in S_FIN and S_OUT;
// rejects found before the sweep go straight to S_FIN. The result is
// shown for one cycle with done_o; the receiver cannot stall it.
`default_nettype none
module ttl_dedup_event_table (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic [1:0]  opcode_i,
  input  wire logic [63:0] now_time_i,
  input  wire logic [63:0] event_key_i,
  input  wire logic [63:0] content_print_i,
  input  wire logic        schema_ok_i,
  input  wire logic [63:0] device_tag_i,
  input  wire logic [63:0] boot_tag_i,
  input  wire logic [15:0] ttl_request_i,
  input  wire logic [1:0]  severity_in_i,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic        cfg_index_i,
  input  wire logic [63:0] cfg_data_i,
  output logic             done_o,
  output logic [3:0]       status_o,
  output logic             accepted_o,
  output logic             found_o,
  output logic [1:0]       severity_out_o,
  output logic [63:0]      key_out_o,
  output logic [14:0]      remaining_ms_o
);
  import tdet_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_FIN  = 4'b0100,
    S_OUT  = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic [63:0] own_dev_q, own_boot_q;
  logic [1:0]  op_q;
  logic [63:0] now_q, key_q, print_q;
  logic [14:0] ttl_q;
  logic [1:0]  sev_q;
  logic [CntW-1:0] cnt_q;       // read address counter
  logic [SlotW-1:0] cmp_idx_q;  // slot whose data is on the read port
  logic        cmp_vld_q;
  logic        hit_q, hit_d;
  logic [SlotW-1:0] hit_idx_q, hit_idx_d;
  logic        hit_done_q, hit_done_d;
  logic        best_q, best_d;
  logic [1:0]  best_sev_q, best_sev_d;
  logic [63:0] best_key_q, best_key_d, best_dl_q, best_dl_d;
  logic [3:0]  early_st_q;
  logic        early_q;
  res_t        res_q, res_d;

  rec_t rd_rec, wr_rec;
  logic [Slots-1:0] used, emitted;
  logic wr_en, emit_en;
  logic [SlotW-1:0] wr_idx;
  logic take;

  tdet_store u_store (
    .clk_i, .rst_ni,
    .rd_idx_i(cnt_q[SlotW-1:0]), .rd_rec_o(rd_rec),
    .used_o(used), .emitted_o(emitted),
    .wr_i(wr_en), .wr_idx_i(wr_idx), .wr_rec_i(wr_rec),
    .emit_i(emit_en), .emit_idx_i(hit_idx_q)
  );

  assign take = start_i && !busy_o;
  assign busy_o = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_dev_q <= '0;
      own_boot_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgDevice: own_dev_q <= cfg_data_i;
        CfgBoot:   own_boot_q <= cfg_data_i;
        default:   ;
      endcase
    end
  end

  // pre-sweep checks for submit
  logic [3:0] early_st;
  logic early;
  always_comb begin
    early = 1'b1;
    early_st = StAccepted;
    if (!schema_ok_i || severity_in_i == 2'd3) early_st = StSchema;
    else if (device_tag_i != own_dev_q) early_st = StDevice;
    else if (boot_tag_i != own_boot_q) early_st = StBoot;
    else if (ttl_request_i == 16'd0 || ttl_request_i > {1'b0, TtlMax}) early_st = StTtl;
    else early = 1'b0;
    if (opcode_i != OpSubmit) early = 1'b0;
  end

  // per-slot compare on the read data
  logic live, exp_now, less_sev;
  logic [63:0] diff;
  always_comb begin
    live = cmp_vld_q && used[cmp_idx_q];
    exp_now = now_q >= rd_rec.deadline;
    less_sev = rd_rec.severity > best_sev_q;
    hit_d = hit_q;
    hit_idx_d = hit_idx_q;
    hit_done_d = hit_done_q;
    best_d = best_q;
    best_sev_d = best_sev_q;
    best_key_d = best_key_q;
    best_dl_d = best_dl_q;
    if (live && !hit_done_q) begin
      case (op_q)
        OpSubmit: if (rd_rec.key == key_q) begin
          hit_d = 1'b1; hit_idx_d = cmp_idx_q; hit_done_d = 1'b1;
          best_key_d = rd_rec.print; best_dl_d = rd_rec.deadline;
          best_sev_d = rd_rec.severity;
          best_d = (rd_rec.print != print_q) || (ttl_q > rd_rec.first_ttl);
        end
        OpExpire: if (!emitted[cmp_idx_q] && exp_now) begin
          hit_d = 1'b1; hit_idx_d = cmp_idx_q; hit_done_d = 1'b1;
          best_sev_d = rd_rec.severity; best_key_d = rd_rec.key;
        end
        default: if (!exp_now && (!hit_q || less_sev)) begin
          hit_d = 1'b1; hit_idx_d = cmp_idx_q;
          best_sev_d = rd_rec.severity; best_key_d = rd_rec.key;
          best_dl_d = rd_rec.deadline;
        end
      endcase
    end
    diff = best_dl_q - now_q;
  end

  logic [14:0] left;
  assign left = (diff > {49'd0, TtlMax}) ? TtlMax : diff[14:0];

  // free slot choice
  logic free_ok;
  logic [SlotW-1:0] free_idx;
  always_comb begin
    free_ok = 1'b0;
    free_idx = '0;
    for (int i = Slots - 1; i >= 0; i--) begin
      if (emitted[i]) begin free_ok = 1'b1; free_idx = SlotW'(i); end
    end
    for (int i = Slots - 1; i >= 0; i--) begin
      if (!used[i]) begin free_ok = 1'b1; free_idx = SlotW'(i); end
    end
  end

  logic ovf;
  assign ovf = now_q > (64'hFFFF_FFFF_FFFF_FFFF - {49'd0, ttl_q});

  always_comb begin
    res_d = '0;
    wr_en = 1'b0;
    emit_en = 1'b0;
    wr_idx = free_idx;
    wr_rec.key = key_q;
    wr_rec.print = print_q;
    wr_rec.deadline = now_q + {49'd0, ttl_q};
    wr_rec.first_ttl = ttl_q;
    wr_rec.severity = sev_q;
    if (early_q) begin
      res_d.status = early_st_q;
      res_d.severity = (early_st_q == StSchema) ? 2'd0 : sev_q;
    end else begin
      case (op_q)
        OpSubmit: begin
          res_d.severity = sev_q;
          if (hit_q) begin
            if (best_q) res_d.status = StConflict;
            else if (now_q >= best_dl_q) res_d.status = StExpired;
            else begin
              res_d.status = StDuplicate;
              res_d.accepted = 1'b1;
              res_d.severity = best_sev_q;
              res_d.remaining = left;
            end
          end else if (!free_ok || ovf) begin
            res_d.status = StCapacity;
          end else begin
            res_d.status = StAccepted;
            res_d.accepted = 1'b1;
            res_d.remaining = ttl_q;
            wr_en = (state_q == S_FIN);
          end
        end
        OpExpire: if (hit_q) begin
          res_d.found = 1'b1;
          res_d.severity = best_sev_q;
          res_d.key = best_key_q;
          emit_en = (state_q == S_FIN);
        end
        OpQuery: if (hit_q) begin
          res_d.found = 1'b1;
          res_d.severity = best_sev_q;
          res_d.key = best_key_q;
          res_d.remaining = left;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (take) state_d = early ? S_FIN : S_SCAN;
      S_SCAN: if (cmp_vld_q && cmp_idx_q == SlotW'(Slots - 1)) state_d = S_FIN;
      S_FIN:  state_d = S_OUT;
      S_OUT:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q <= '0;
      cmp_vld_q <= 1'b0;
      hit_q <= 1'b0;
      hit_done_q <= 1'b0;
      early_q <= 1'b0;
      done_o <= 1'b0;
    end else begin
      state_q <= state_d;
      done_o <= (state_q == S_FIN);
      if (take) begin
        cnt_q <= '0;
        cmp_vld_q <= 1'b0;
        hit_q <= 1'b0;
        hit_done_q <= 1'b0;
        early_q <= early;
      end else if (state_q == S_SCAN) begin
        cmp_vld_q <= (cnt_q < CntW'(Slots));
        if (cnt_q < CntW'(Slots)) cnt_q <= cnt_q + 1'b1;
        hit_q <= hit_d;
        hit_done_q <= hit_done_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      op_q <= opcode_i;
      now_q <= now_time_i;
      key_q <= event_key_i;
      print_q <= content_print_i;
      ttl_q <= ttl_request_i[14:0];
      sev_q <= severity_in_i;
      early_st_q <= early_st;
      best_q <= 1'b0;
      best_sev_q <= '0;
    end else if (state_q == S_SCAN) begin
      cmp_idx_q <= cnt_q[SlotW-1:0];
      hit_idx_q <= hit_idx_d;
      best_q <= best_d;
      best_sev_q <= best_sev_d;
      best_key_q <= best_key_d;
      best_dl_q <= best_dl_d;
    end
    if (state_q == S_FIN) res_q <= res_d;
  end

  assign status_o = res_q.status;
  assign accepted_o = res_q.accepted;
  assign found_o = res_q.found;
  assign severity_out_o = res_q.severity;
  assign key_out_o = res_q.key;
  assign remaining_ms_o = res_q.remaining;
endmodule
`default_nettype wire

/* hw/rtl/tdet_checker.sv */
// ----------------------------------------------------------------------------
// tdet_checker
// Port level checks of the timed event dedup table.
// ----------------------------------------------------------------------------
`default_nettype none
module tdet_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        start_i,
  input wire logic        busy_o,
  input wire logic        done_o,
  input wire logic [3:0]  status_o,
  input wire logic        accepted_o,
  input wire logic [14:0] remaining_ms_o
);
  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o) else $error("no busy after start");
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy_o) else $error("result beat while idle");
  a_acc_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && accepted_o |-> (status_o == 4'd0 || status_o == 4'd1))
    else $error("accepted with reject status");
  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> remaining_ms_o <= 15'd30000) else $error("remaining out of range");
  a_idle_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy_o) else $error("busy after result beat");
endmodule

bind ttl_dedup_event_table tdet_checker u_tdet_checker (
  .clk_i, .rst_ni, .start_i, .busy_o, .done_o, .status_o, .accepted_o,
  .remaining_ms_o
);
`default_nettype wire

/* test/ttl_dedup_event_table_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ttl_dedup_event_table_checker
// Watches the command, config and result channels of the event table, keeps
// a shadow copy of the slot table and compares each result beat in order.
// ----------------------------------------------------------------------------
module ttl_dedup_event_table_checker
  import tdet_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_o,
  input  logic [1:0]  opcode_i,
  input  logic [63:0] now_time_i,
  input  logic [63:0] event_key_i,
  input  logic [63:0] content_print_i,
  input  logic        schema_ok_i,
  input  logic [63:0] device_tag_i,
  input  logic [63:0] boot_tag_i,
  input  logic [15:0] ttl_request_i,
  input  logic [1:0]  severity_in_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [63:0] cfg_data_i,
  input  logic        done_o,
  input  logic [3:0]  status_o,
  input  logic        accepted_o,
  input  logic        found_o,
  input  logic [1:0]  severity_out_o,
  input  logic [63:0] key_out_o,
  input  logic [14:0] remaining_ms_o,
  output int          fail_cnt_o,
  output int          pending_o
);
  logic [63:0] own_dev, own_boot;
  logic        used_q [Slots];
  logic        emit_q [Slots];
  rec_t        rec_q  [Slots];
  res_t        expected_q [$];

  assign pending_o = expected_q.size();

  function automatic logic [14:0] time_left(logic [63:0] dl, logic [63:0] now);
    logic [63:0] d;
    d = dl - now;
    return (d > 64'(TtlMax)) ? TtlMax : d[14:0];
  endfunction

  function automatic res_t mk(logic [3:0] st, logic acc, logic fnd, logic [1:0] sev,
                              logic [63:0] k, logic [14:0] rem);
    res_t r;
    r.status = st; r.accepted = acc; r.found = fnd;
    r.severity = sev; r.key = k; r.remaining = rem;
    return r;
  endfunction

  task automatic table_step();
    int          fr, best;
    logic [63:0] now;
    logic [16:0] ttl;
    res_t        r;
    bit          done;
    now = now_time_i; ttl = {1'b0, ttl_request_i}; fr = -1; best = -1; done = 0;
    r = mk(StAccepted, 0, 0, 0, 0, 0);
    case (opcode_i)
      OpSubmit: begin
        if (!schema_ok_i || severity_in_i > 2) r = mk(StSchema, 0, 0, 0, 0, 0);
        else if (device_tag_i != own_dev) r = mk(StDevice, 0, 0, severity_in_i, 0, 0);
        else if (boot_tag_i != own_boot) r = mk(StBoot, 0, 0, severity_in_i, 0, 0);
        else if (ttl == 0 || ttl > 17'(TtlMax)) r = mk(StTtl, 0, 0, severity_in_i, 0, 0);
        else begin
          for (int i = 0; i < Slots && !done; i++) begin
            if (!used_q[i]) begin
              if (fr < 0) fr = i;
            end else if (rec_q[i].key == event_key_i) begin
              done = 1;
              if (rec_q[i].print != content_print_i || ttl > 17'(rec_q[i].first_ttl))
                r = mk(StConflict, 0, 0, severity_in_i, 0, 0);
              else if (now >= rec_q[i].deadline)
                r = mk(StExpired, 0, 0, severity_in_i, 0, 0);
              else
                r = mk(StDuplicate, 1, 0, rec_q[i].severity, 0,
                       time_left(rec_q[i].deadline, now));
            end
          end
          if (!done) begin
            if (fr < 0)
              for (int i = Slots - 1; i >= 0; i--) if (emit_q[i]) fr = i;
            if (fr < 0 || now > ~64'd0 - 64'(ttl))
              r = mk(StCapacity, 0, 0, severity_in_i, 0, 0);
            else begin
              used_q[fr] = 1; emit_q[fr] = 0;
              rec_q[fr].key = event_key_i; rec_q[fr].print = content_print_i;
              rec_q[fr].deadline = now + 64'(ttl);
              rec_q[fr].first_ttl = ttl[14:0]; rec_q[fr].severity = severity_in_i;
              r = mk(StAccepted, 1, 0, severity_in_i, 0, ttl[14:0]);
            end
          end
        end
      end
      OpExpire: begin
        for (int i = 0; i < Slots && !done; i++)
          if (used_q[i] && !emit_q[i] && now >= rec_q[i].deadline) begin
            done = 1; emit_q[i] = 1;
            r = mk(StAccepted, 0, 1, rec_q[i].severity, rec_q[i].key, 0);
          end
      end
      OpQuery: begin
        for (int i = 0; i < Slots; i++)
          if (used_q[i] && now < rec_q[i].deadline &&
              (best < 0 || rec_q[i].severity > rec_q[best].severity)) best = i;
        if (best >= 0)
          r = mk(StAccepted, 0, 1, rec_q[best].severity, rec_q[best].key,
                 time_left(rec_q[best].deadline, now));
      end
      default: ;
    endcase
    expected_q.push_back(r);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    res_t e;
    if (!rst_ni) begin
      own_dev = '0; own_boot = '0; fail_cnt_o <= 0;
      for (int i = 0; i < Slots; i++) begin
        used_q[i] = 0; emit_q[i] = 0;
      end
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == CfgDevice) own_dev = cfg_data_i;
        else own_boot = cfg_data_i;
      end
      if (done_o) begin
        if (expected_q.size() == 0) begin
          $error("result beat with nothing expected");
          fail_cnt_o <= fail_cnt_o + 1;
        end else begin
          e = expected_q.pop_front();
          if (e.status != status_o || e.accepted != accepted_o || e.found != found_o ||
              e.severity != severity_out_o || e.key != key_out_o ||
              e.remaining != remaining_ms_o) begin
            fail_cnt_o <= fail_cnt_o + 1;
            if (e.status != status_o) $error("status exp %0d got %0d", e.status, status_o);
            if (e.accepted != accepted_o)
              $error("accepted exp %0d got %0d", e.accepted, accepted_o);
            if (e.found != found_o) $error("found exp %0d got %0d", e.found, found_o);
            if (e.severity != severity_out_o)
              $error("severity_out exp %0d got %0d", e.severity, severity_out_o);
            if (e.key != key_out_o) $error("key_out exp %h got %h", e.key, key_out_o);
            if (e.remaining != remaining_ms_o)
              $error("remaining_ms exp %0d got %0d", e.remaining, remaining_ms_o);
          end
        end
      end
      if (start_i && !busy_o) table_step();
    end
  end
endmodule

/* test/tb_ttl_dedup_event_table.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ttl_dedup_event_table
// Drives config writes and table commands (directed, then random submit,
// expire and query traffic on a small key set) and reports the verdict.
// ----------------------------------------------------------------------------
module tb_ttl_dedup_event_table;
  import tdet_pkg::*;

  logic        clk = 0, rst_n = 0;
  logic        start = 0, busy;
  logic [1:0]  opcode = 0;
  logic [63:0] now_t = 0, ev_key = 0, c_print = 0, dev_tag = 0, boot_tag = 0;
  logic        schema_ok = 0;
  logic [15:0] ttl_req = 0;
  logic [1:0]  sev_in = 0;
  logic        cfg_valid = 0, cfg_ready, cfg_index = 0;
  logic [63:0] cfg_data = 0;
  logic        done, accepted, found;
  logic [3:0]  status;
  logic [1:0]  sev_out;
  logic [63:0] key_out;
  logic [14:0] remaining;
  int          fail_cnt, pending;
  logic [63:0] cur_dev, cur_boot, clock_ms;
  bit          no_gaps;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  ttl_dedup_event_table dut (
    .clk_i(clk), .rst_ni(rst_n), .start_i(start), .busy_o(busy), .opcode_i(opcode),
    .now_time_i(now_t), .event_key_i(ev_key), .content_print_i(c_print),
    .schema_ok_i(schema_ok), .device_tag_i(dev_tag), .boot_tag_i(boot_tag),
    .ttl_request_i(ttl_req), .severity_in_i(sev_in), .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready), .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .done_o(done), .status_o(status), .accepted_o(accepted), .found_o(found),
    .severity_out_o(sev_out), .key_out_o(key_out), .remaining_ms_o(remaining)
  );

  ttl_dedup_event_table_checker chk (
    .clk_i(clk), .rst_ni(rst_n), .start_i(start), .busy_o(busy), .opcode_i(opcode),
    .now_time_i(now_t), .event_key_i(ev_key), .content_print_i(c_print),
    .schema_ok_i(schema_ok), .device_tag_i(dev_tag), .boot_tag_i(boot_tag),
    .ttl_request_i(ttl_req), .severity_in_i(sev_in), .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready), .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .done_o(done), .status_o(status), .accepted_o(accepted), .found_o(found),
    .severity_out_o(sev_out), .key_out_o(key_out), .remaining_ms_o(remaining),
    .fail_cnt_o(fail_cnt), .pending_o(pending)
  );

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  task automatic cfg_write(logic idx, logic [63:0] val);
    cfg_valid <= 1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    if (idx == CfgDevice) cur_dev = val; else cur_boot = val;
    @(posedge clk);
  endtask

  task automatic drain();
    while (pending != 0) @(posedge clk);
    repeat (25) @(posedge clk);
  endtask

  task automatic issue(logic [1:0] op, logic [63:0] now, logic [63:0] k, logic [63:0] p,
                       logic sok, logic [63:0] dt, logic [63:0] bt, logic [15:0] ttl,
                       logic [1:0] sev);
    if (!no_gaps && $urandom_range(0, 5) == 0) repeat ($urandom_range(1, 9)) @(posedge clk);
    start <= 1; opcode <= op; now_t <= now; ev_key <= k; c_print <= p;
    schema_ok <= sok; dev_tag <= dt; boot_tag <= bt; ttl_req <= ttl; sev_in <= sev;
    @(posedge clk);
    while (busy) @(posedge clk);
    start <= 0;
    @(posedge clk);
  endtask

  task automatic sub(logic [63:0] now, logic [63:0] k, logic [63:0] p, logic [15:0] ttl,
                     logic [1:0] sev);
    issue(OpSubmit, now, k, p, 1, cur_dev, cur_boot, ttl, sev);
  endtask

  task automatic random_item();
    int          sel;
    logic [63:0] k, p;
    sel = $urandom_range(0, 99);
    k = 64'($urandom_range(0, 23));
    p = k ^ 64'($urandom_range(0, 12) == 0);
    clock_ms += 64'($urandom_range(0, 3000));
    if ($urandom_range(0, 30) == 0) clock_ms -= 64'($urandom_range(0, 40000));
    if (sel < 55)
      sub(clock_ms, k, p, 16'($urandom_range(1, 30000)), 2'($urandom_range(0, 2)));
    else if (sel < 70) issue(OpExpire, clock_ms, rnd64(), rnd64(), 1, 0, 0, 0, 0);
    else if (sel < 85) issue(OpQuery, clock_ms, rnd64(), rnd64(), 0, 0, 0, 0, 0);
    else if (sel < 88) issue(2'd3, rnd64(), rnd64(), rnd64(), 1, 0, 0, 0, 0);
    else if (sel < 90)
      sub(~64'd0 - 64'($urandom_range(0, 40000)), rnd64(), rnd64(),
          16'($urandom_range(1, 30000)), 2'($urandom_range(0, 2)));
    else
      issue(OpSubmit, clock_ms, k, p, $urandom_range(0, 3) != 0,
            $urandom_range(0, 3) ? cur_dev : rnd64(),
            $urandom_range(0, 3) ? cur_boot : rnd64(), 16'($urandom), 2'($urandom));
  endtask

  initial begin
    #100ms;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    no_gaps = 0; cur_dev = 0; cur_boot = 0; clock_ms = 1000;
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    cfg_write(CfgDevice, ~64'd0);
    cfg_write(CfgBoot, 64'd0);
    // directed: rejects, extremes, duplicate, conflict, expiry, capacity
    issue(OpQuery, 0, 0, 0, 0, 0, 0, 0, 0);
    issue(OpExpire, 0, 0, 0, 0, 0, 0, 0, 0);
    issue(OpSubmit, 100, 1, 1, 0, cur_dev, cur_boot, 10, 1);
    issue(OpSubmit, 100, 1, 1, 1, cur_dev, cur_boot, 10, 3);
    issue(OpSubmit, 100, 1, 1, 1, 64'd5, cur_boot, 10, 1);
    issue(OpSubmit, 100, 1, 1, 1, cur_dev, ~64'd0, 10, 1);
    sub(100, 1, 1, 0, 1);
    sub(100, 1, 1, 30001, 1);
    sub(100, 1, 1, 16'hFFFF, 1);
    sub(100, ~64'd0, ~64'd0, 30000, 2);
    sub(100, 2, 2, 1, 0);
    sub(100, ~64'd0, ~64'd0, 20000, 1);
    sub(100, ~64'd0, 64'd7, 100, 1);
    sub(100, ~64'd0, ~64'd0, 30000, 0);
    sub(~64'd0, 3, 3, 1, 0);
    issue(OpQuery, 50, 0, 0, 0, 0, 0, 0, 0);
    issue(OpExpire, 200, 0, 0, 0, 0, 0, 0, 0);
    sub(200, 2, 2, 1, 0);
    for (int i = 0; i < 15; i++) sub(300, 64'(100 + i), 0, 5, 2'(i % 3));
    sub(300, 500, 0, 5, 0);
    issue(2'd3, ~64'd0, ~64'd0, ~64'd0, 1, ~64'd0, ~64'd0, 16'hFFFF, 3);
    sub(400, 2, 2, 1, 0);
    drain();
    for (int ph = 0; ph < 4; ph++) begin
      if (ph == 1) begin
        cfg_write(CfgDevice, rnd64()); cfg_write(CfgBoot, rnd64());
      end else if (ph == 2) begin
        cfg_write(CfgDevice, 64'd0); cfg_write(CfgBoot, ~64'd0);
      end else if (ph == 3) begin
        cfg_write(CfgDevice, rnd64()); cfg_write(CfgBoot, rnd64());
        no_gaps = 1;
      end
      for (int n = 0; n < 125; n++) random_item();
      drain();
    end
    if (fail_cnt == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end
endmodule
